// ===== hw/rtl/cfp_pkg.sv =====
// shared types and constants of the pair contact force pipeline
`default_nettype none

package cfp_pkg;

  localparam int unsigned FIX_W = 32;            // signed q16.16 fields
  localparam int unsigned POS_W = 31;            // unsigned q15.16 fields
  localparam int unsigned DIF_W = POS_W + 2;     // difference of two signed fields
  localparam int unsigned MAG_W = FIX_W;         // magnitude of such a difference
  localparam int unsigned SQ_W  = 2 * FIX_W;     // sum of squares
  localparam int unsigned RR_W  = FIX_W;         // integer square root
  localparam int unsigned QE_W  = POS_W;         // unit normal magnitude, q1.30

  localparam int unsigned FOLD_LAT  = MAG_W + 1;
  localparam int unsigned ISQRT_LAT = RR_W;
  localparam int unsigned DIV_LAT   = QE_W;
  localparam int unsigned FORCE_LAT = 6;
  localparam int unsigned PIPE_LAT  = 4 + FOLD_LAT + ISQRT_LAT + DIV_LAT + FORCE_LAT;

  localparam logic [POS_W-1:0] BOX_RESET = 31'd65536;

  typedef enum logic {
    CFG_BOX_WIDTH  = 1'b0,
    CFG_BOX_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e         index;
    logic [POS_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] a_pos_x;
    logic signed [FIX_W-1:0] a_pos_y;
    logic signed [FIX_W-1:0] b_pos_x;
    logic signed [FIX_W-1:0] b_pos_y;
    logic signed [FIX_W-1:0] a_vel_x;
    logic signed [FIX_W-1:0] a_vel_y;
    logic signed [FIX_W-1:0] b_vel_x;
    logic signed [FIX_W-1:0] b_vel_y;
    logic [POS_W-1:0]        radius_sum;
    logic [POS_W-1:0]        stiffness_sum;
    logic [POS_W-1:0]        damping_sum;
    logic [1:0]              free_flags;
  } pair_t;

  typedef struct packed {
    logic                    in_contact;
    logic signed [FIX_W-1:0] a_force_x;
    logic signed [FIX_W-1:0] a_force_y;
    logic signed [FIX_W-1:0] b_force_x;
    logic signed [FIX_W-1:0] b_force_y;
  } force_t;

  typedef struct packed {
    logic [QE_W-1:0]         qx;
    logic [QE_W-1:0]         qy;
    logic                    neg_x;
    logic                    neg_y;
    logic signed [DIF_W-1:0] dvx;
    logic signed [DIF_W-1:0] dvy;
    logic [POS_W-1:0]        xi;
    logic [POS_W-1:0]        stiffness_sum;
    logic [POS_W-1:0]        damping_sum;
    logic [1:0]              free_flags;
    logic                    in_contact;
  } force_in_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfp_if.sv =====
// handshake channels for configuration, pair items and force items
`default_nettype none

interface cfp_cfg_if;
  logic          valid;
  logic          ready;
  cfp_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfp_pair_if;
  logic           valid;
  logic           ready;
  cfp_pkg::pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfp_force_if;
  logic            valid;
  logic            ready;
  cfp_pkg::force_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cfp_fold.sv =====
// pipelined minimum image fold of one axis, one remainder bit per stage
`default_nettype none

module cfp_fold (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [cfp_pkg::DIF_W-1:0]     d_i,
  input  logic        [cfp_pkg::POS_W-1:0]     len_i,
  output logic signed [cfp_pkg::DIF_W-1:0]     m_o
);

  localparam int unsigned DW = cfp_pkg::DIF_W;
  localparam int unsigned MW = cfp_pkg::MAG_W;
  localparam int unsigned PW = cfp_pkg::POS_W;
  localparam int unsigned SW = cfp_pkg::SQ_W;

  logic        [MW-1:0] rem_q [MW];
  logic signed [DW-1:0] d_q   [MW];
  logic        [MW-1:0] r;
  logic        [PW-1:0] m0;
  logic                 neg;
  logic signed [DW-1:0] m_d;
  logic signed [DW-1:0] m_q;

  for (genvar j = 0; j < MW; j++) begin : g_step
    logic        [MW-1:0] rem_in;
    logic signed [DW-1:0] d_in;
    logic        [SW-1:0] sub;
    if (j == 0) begin : g_first
      assign d_in   = d_i;
      assign rem_in = d_i[DW-1] ? MW'(-d_i) : d_i[MW-1:0];
    end else begin : g_next
      assign d_in   = d_q[j-1];
      assign rem_in = rem_q[j-1];
    end
    assign sub = {{(SW-PW){1'b0}}, len_i} << (MW - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j] <= d_in;
        if ({{(SW-MW){1'b0}}, rem_in} >= sub) begin
          rem_q[j] <= rem_in - sub[MW-1:0];
        end else begin
          rem_q[j] <= rem_in;
        end
      end
    end
  end

  // floor remainder, then fold into (-len/2, len/2]
  always_comb begin
    r   = rem_q[MW-1];
    neg = d_q[MW-1][DW-1];
    m0  = r[PW-1:0];
    if (neg && (r != '0)) begin
      m0 = len_i - r[PW-1:0];
    end
    if ({m0, 1'b0} > {1'b0, len_i}) begin
      m_d = {2'b00, m0} - {2'b00, len_i};
    end else begin
      m_d = {2'b00, m0};
    end
    if (len_i == '0) begin
      m_d = d_q[MW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
    end
  end

  assign m_o = m_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_isqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none

module cfp_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cfp_pkg::SQ_W-1:0]    v_i,
  output logic [cfp_pkg::RR_W-1:0]    root_o
);

  localparam int unsigned SW = cfp_pkg::SQ_W;
  localparam int unsigned RW = cfp_pkg::RR_W;
  localparam int unsigned EW = RW + 4;

  logic [RW-1:0] root_q [RW];
  logic [EW-1:0] rem_q  [RW-1];
  logic [SW-1:0] v_q    [RW-1];

  for (genvar j = 0; j < RW; j++) begin : g_step
    logic [RW-1:0] root_in;
    logic [EW-1:0] rem_in;
    logic [SW-1:0] v_in;
    logic [EW-1:0] rem_sh;
    logic [EW-1:0] trial;
    logic          take;
    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign v_in    = v_i;
    end else begin : g_next
      assign root_in = root_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign v_in    = v_q[j-1];
    end
    assign rem_sh = {rem_in[EW-3:0], v_in[SW-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign take   = rem_sh >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= {root_in[RW-2:0], take};
      end
    end
    if (j < RW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_sh - trial) : rem_sh;
          v_q[j]   <= v_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_div.sv =====
// pipelined restoring divider for the unit normal, one quotient bit per stage
`default_nettype none

module cfp_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cfp_pkg::QE_W-1:0]    num_i,
  input  logic [cfp_pkg::QE_W-1:0]    den_i,
  output logic [cfp_pkg::QE_W-1:0]    q_o
);

  localparam int unsigned QW = cfp_pkg::QE_W;
  localparam int unsigned RW = QW + 1;

  logic [QW-1:0] q_q   [QW];
  logic [RW-1:0] rem_q [QW-1];
  logic [QW-1:0] den_q [QW-1];

  // quotient of num * 2^30 / den, num not above den
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] den_in;
    logic          bit_in;
    logic [RW-1:0] rem_sh;
    logic          take;
    if (j == 0) begin : g_first
      assign rem_in = {2'b00, num_i[QW-1:1]};
      assign q_in   = '0;
      assign den_in = den_i;
      assign bit_in = num_i[0];
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
      assign den_in = den_q[j-1];
      assign bit_in = 1'b0;
    end
    assign rem_sh = {rem_in[RW-2:0], bit_in};
    assign take   = rem_sh >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j] <= {q_in[QW-2:0], take};
      end
    end
    if (j < QW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_sh - {1'b0, den_in}) : rem_sh;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_force.sv =====
// overlap rate, spring-dashpot normal force and saturated force components
`default_nettype none

module cfp_force (
  input  logic                clk_i,
  input  logic                en_i,
  input  cfp_pkg::force_in_t  in_i,
  output cfp_pkg::force_t     out_o
);

  localparam int unsigned QW = cfp_pkg::QE_W;
  localparam int unsigned PW = cfp_pkg::POS_W;
  localparam int unsigned MW = cfp_pkg::MAG_W;
  localparam int unsigned DW = cfp_pkg::DIF_W;
  localparam int unsigned FW = cfp_pkg::FIX_W;
  localparam int unsigned PX_W = QW + MW;          // e times velocity difference
  localparam int unsigned EL_W = 2 * PW - 17;      // elastic term
  localparam int unsigned XD_W = 35;               // overlap rate
  localparam int unsigned DS_W = PW + XD_W - 1 - 17;
  localparam int unsigned FN_W = 49;
  localparam int unsigned LO_W = 25;
  localparam int unsigned HI_W = FN_W - LO_W;
  localparam int unsigned FP_W = FN_W + QW;

  function automatic logic signed [FW-1:0] sat_mag(input logic neg,
                                                   input logic [FP_W-31:0] m);
    logic signed [FW-1:0] res;
    if (neg) begin
      if (m > (FP_W-30)'(64'd2147483648)) begin
        res = {1'b1, {(FW-1){1'b0}}};
      end else begin
        res = -m[FW-1:0];
      end
    end else begin
      if (m > (FP_W-30)'(64'd2147483647)) begin
        res = {1'b0, {(FW-1){1'b1}}};
      end else begin
        res = m[FW-1:0];
      end
    end
    return res;
  endfunction

  // stage 1
  logic [PX_W-1:0]     px1_q, py1_q;
  logic                pnx1_q, pny1_q;
  logic [EL_W-1:0]     el1_q;
  logic [QW-1:0]       qx1_q, qy1_q;
  logic                nx1_q, ny1_q, ct1_q;
  logic [PW-1:0]       damp1_q;
  logic [1:0]          fl1_q;
  logic [MW-1:0]       dvx_mag, dvy_mag;
  logic [2*PW-1:0]     el_p;
  // stage 2
  logic signed [XD_W-1:0] spx, spy;
  logic signed [XD_W-1:0] xd2_q;
  logic [EL_W-1:0]     el2_q;
  logic [QW-1:0]       qx2_q, qy2_q;
  logic                nx2_q, ny2_q, ct2_q;
  logic [PW-1:0]       damp2_q;
  logic [1:0]          fl2_q;
  // stage 3
  logic [XD_W-2:0]     xd_mag;
  logic [PW+XD_W-2:0]  ds_p;
  logic [DS_W-1:0]     ds3_q;
  logic                dn3_q;
  logic [EL_W-1:0]     el3_q;
  logic [QW-1:0]       qx3_q, qy3_q;
  logic                nx3_q, ny3_q, ct3_q;
  logic [1:0]          fl3_q;
  // stage 4
  logic signed [FN_W:0] fn_s;
  logic [FN_W-1:0]     fn4_q;
  logic [QW-1:0]       qx4_q, qy4_q;
  logic                nx4_q, ny4_q, ct4_q;
  logic [1:0]          fl4_q;
  // stage 5
  logic [LO_W+QW-1:0]  lx5_q, ly5_q;
  logic [HI_W+QW-1:0]  hx5_q, hy5_q;
  logic                nx5_q, ny5_q, ct5_q;
  logic [1:0]          fl5_q;
  // stage 6
  logic [FP_W-1:0]     fx_full, fy_full;
  logic [FP_W-31:0]    mx, my;
  cfp_pkg::force_t     out_d, out_q;

  assign dvx_mag = in_i.dvx[DW-1] ? MW'(-in_i.dvx) : in_i.dvx[MW-1:0];
  assign dvy_mag = in_i.dvy[DW-1] ? MW'(-in_i.dvy) : in_i.dvy[MW-1:0];
  assign el_p    = in_i.stiffness_sum * in_i.xi;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q   <= in_i.qx * dvx_mag;
      py1_q   <= in_i.qy * dvy_mag;
      pnx1_q  <= in_i.neg_x ^ in_i.dvx[DW-1];
      pny1_q  <= in_i.neg_y ^ in_i.dvy[DW-1];
      el1_q   <= el_p[2*PW-1:17];
      qx1_q   <= in_i.qx;
      qy1_q   <= in_i.qy;
      nx1_q   <= in_i.neg_x;
      ny1_q   <= in_i.neg_y;
      ct1_q   <= in_i.in_contact;
      damp1_q <= in_i.damping_sum;
      fl1_q   <= in_i.free_flags;
    end
  end

  // overlap rate is minus the projected relative velocity
  assign spx = pnx1_q ? -{2'b00, px1_q[PX_W-1:30]} : {2'b00, px1_q[PX_W-1:30]};
  assign spy = pny1_q ? -{2'b00, py1_q[PX_W-1:30]} : {2'b00, py1_q[PX_W-1:30]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xd2_q   <= -(spx + spy);
      el2_q   <= el1_q;
      qx2_q   <= qx1_q;
      qy2_q   <= qy1_q;
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      ct2_q   <= ct1_q;
      damp2_q <= damp1_q;
      fl2_q   <= fl1_q;
    end
  end

  assign xd_mag = xd2_q[XD_W-1] ? (XD_W-1)'(-xd2_q) : xd2_q[XD_W-2:0];
  assign ds_p   = damp2_q * xd_mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds3_q <= ds_p[PW+XD_W-2:17];
      dn3_q <= xd2_q[XD_W-1];
      el3_q <= el2_q;
      qx3_q <= qx2_q;
      qy3_q <= qy2_q;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      ct3_q <= ct2_q;
      fl3_q <= fl2_q;
    end
  end

  // normal force, clamped at zero
  assign fn_s = {{(FN_W+1-EL_W){1'b0}}, el3_q}
              + (dn3_q ? -{{(FN_W+1-DS_W){1'b0}}, ds3_q}
                       :  {{(FN_W+1-DS_W){1'b0}}, ds3_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fn4_q <= fn_s[FN_W] ? '0 : fn_s[FN_W-1:0];
      qx4_q <= qx3_q;
      qy4_q <= qy3_q;
      nx4_q <= nx3_q;
      ny4_q <= ny3_q;
      ct4_q <= ct3_q;
      fl4_q <= fl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx5_q <= fn4_q[LO_W-1:0] * qx4_q;
      ly5_q <= fn4_q[LO_W-1:0] * qy4_q;
      hx5_q <= fn4_q[FN_W-1:LO_W] * qx4_q;
      hy5_q <= fn4_q[FN_W-1:LO_W] * qy4_q;
      nx5_q <= nx4_q;
      ny5_q <= ny4_q;
      ct5_q <= ct4_q;
      fl5_q <= fl4_q;
    end
  end

  assign fx_full = {{(FP_W-LO_W-QW){1'b0}}, lx5_q} + {hx5_q, {LO_W{1'b0}}};
  assign fy_full = {{(FP_W-LO_W-QW){1'b0}}, ly5_q} + {hy5_q, {LO_W{1'b0}}};
  assign mx      = fx_full[FP_W-1:30];
  assign my      = fy_full[FP_W-1:30];

  always_comb begin
    out_d            = '0;
    out_d.in_contact = ct5_q;
    if (ct5_q && fl5_q[0]) begin
      out_d.a_force_x = sat_mag(nx5_q, mx);
      out_d.a_force_y = sat_mag(ny5_q, my);
    end
    if (ct5_q && fl5_q[1]) begin
      out_d.b_force_x = sat_mag(!nx5_q, mx);
      out_d.b_force_y = sat_mag(!ny5_q, my);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/contact_force_pair.sv =====
// top level of the pair contact force pipeline
//
// cfg_i takes register writes (box width, box height) at any time it is valid;
// it is always ready, and a write is meant to happen only while no item is in
// flight. both box lengths reset to 1.0, a length of zero turns off the fold.
// pair_i takes one particle pair per cycle while the pipeline is not held,
// force_o gives one force item for each pair, in order.
// an item goes from acceptance to force_o through one input stage, 33 stages
// of minimum image fold (one remainder bit each, then the fold), square and
// sum stages, 32 square root stages, one contact stage, 31 divider stages
// for the unit normal and 6 force stages with split multipliers.
// throughput is one item per cycle while the receiver does not stall.
// reset empties the pipeline and clears all valid bits.
// when the receiver stalls a waiting result, the whole pipeline holds and
// pair_i.ready falls in the same cycle; nothing is lost or repeated.
`default_nettype none

module contact_force_pair (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfp_cfg_if.sink          cfg_i,
  cfp_pair_if.sink         pair_i,
  cfp_force_if.source      force_o
);

  localparam int unsigned DW   = cfp_pkg::DIF_W;
  localparam int unsigned PW   = cfp_pkg::POS_W;
  localparam int unsigned MW   = cfp_pkg::MAG_W;
  localparam int unsigned SW   = cfp_pkg::SQ_W;
  localparam int unsigned RW   = cfp_pkg::RR_W;
  localparam int unsigned QW   = cfp_pkg::QE_W;
  localparam int unsigned NF   = cfp_pkg::FOLD_LAT;
  localparam int unsigned NS   = cfp_pkg::ISQRT_LAT;
  localparam int unsigned ND   = cfp_pkg::DIV_LAT;
  localparam int unsigned NP   = cfp_pkg::PIPE_LAT;

  typedef struct packed {
    logic signed [DW-1:0] dvx;
    logic signed [DW-1:0] dvy;
    logic [PW-1:0]        rs;
    logic [PW-1:0]        stiff;
    logic [PW-1:0]        damp;
    logic [1:0]           flags;
  } side_a_t;

  typedef struct packed {
    logic [PW-1:0] magx;
    logic [PW-1:0] magy;
    logic          negx;
    logic          negy;
    logic          pass;
    side_a_t       a;
  } side_b_t;

  typedef struct packed {
    logic                 negx;
    logic                 negy;
    logic                 rr0;
    logic                 contact;
    logic [PW-1:0]        xi;
    logic signed [DW-1:0] dvx;
    logic signed [DW-1:0] dvy;
    logic [PW-1:0]        stiff;
    logic [PW-1:0]        damp;
    logic [1:0]           flags;
  } side_c_t;

  logic [PW-1:0]        box_width_q, box_height_q;
  logic                 en;
  logic                 valid_q [NP];

  logic signed [DW-1:0] dx_q, dy_q;
  side_a_t              in_sb_q;
  side_a_t              sa_q [NF];
  logic signed [DW-1:0] fold_x, fold_y;

  logic [MW-1:0]        mag_x, mag_y;
  logic [2*PW-1:0]      sqx_q, sqy_q;
  side_b_t              sq_sb_q;
  logic [SW-1:0]        ssum_q;
  side_b_t              sum_sb_q;
  side_b_t              sb_q [NS];
  logic [RW-1:0]        rr;

  side_b_t              sb_last;
  logic [PW-1:0]        ct_magx_q, ct_magy_q, ct_rr_q;
  side_c_t              ct_sb_q;
  side_c_t              sc_q [ND];
  side_c_t              sc_last;
  logic [QW-1:0]        div_x, div_y;

  cfp_pkg::force_in_t   fin;
  cfp_pkg::force_t      fout;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_width_q  <= cfp_pkg::BOX_RESET;
      box_height_q <= cfp_pkg::BOX_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        cfp_pkg::CFG_BOX_WIDTH:  box_width_q  <= cfg_i.data.value;
        cfp_pkg::CFG_BOX_HEIGHT: box_height_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // global advance: move unless a finished item waits at the output
  assign en           = force_o.ready || !valid_q[NP-1];
  assign pair_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= pair_i.valid;
      for (int i = 1; i < NP; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // input stage: differences
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= {pair_i.data.a_pos_x[31], pair_i.data.a_pos_x}
            - {pair_i.data.b_pos_x[31], pair_i.data.b_pos_x};
      dy_q <= {pair_i.data.a_pos_y[31], pair_i.data.a_pos_y}
            - {pair_i.data.b_pos_y[31], pair_i.data.b_pos_y};
      in_sb_q.dvx <= {pair_i.data.a_vel_x[31], pair_i.data.a_vel_x}
                   - {pair_i.data.b_vel_x[31], pair_i.data.b_vel_x};
      in_sb_q.dvy <= {pair_i.data.a_vel_y[31], pair_i.data.a_vel_y}
                   - {pair_i.data.b_vel_y[31], pair_i.data.b_vel_y};
      in_sb_q.rs    <= pair_i.data.radius_sum;
      in_sb_q.stiff <= pair_i.data.stiffness_sum;
      in_sb_q.damp  <= pair_i.data.damping_sum;
      in_sb_q.flags <= pair_i.data.free_flags;
    end
  end

  cfp_fold u_fold_x (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dx_q),
    .len_i (box_width_q),
    .m_o   (fold_x)
  );

  cfp_fold u_fold_y (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dy_q),
    .len_i (box_height_q),
    .m_o   (fold_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= in_sb_q;
      for (int i = 1; i < NF; i++) begin
        sa_q[i] <= sa_q[i-1];
      end
    end
  end

  // box prefilter and squares
  assign mag_x = fold_x[DW-1] ? MW'(-fold_x) : fold_x[MW-1:0];
  assign mag_y = fold_y[DW-1] ? MW'(-fold_y) : fold_y[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q        <= mag_x[PW-1:0] * mag_x[PW-1:0];
      sqy_q        <= mag_y[PW-1:0] * mag_y[PW-1:0];
      sq_sb_q.magx <= mag_x[PW-1:0];
      sq_sb_q.magy <= mag_y[PW-1:0];
      sq_sb_q.negx <= fold_x[DW-1];
      sq_sb_q.negy <= fold_y[DW-1];
      sq_sb_q.pass <= (mag_x < {1'b0, sa_q[NF-1].rs}) && (mag_y < {1'b0, sa_q[NF-1].rs});
      sq_sb_q.a    <= sa_q[NF-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssum_q   <= {2'b00, sqx_q} + {2'b00, sqy_q};
      sum_sb_q <= sq_sb_q;
    end
  end

  cfp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (ssum_q),
    .root_o (rr)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sum_sb_q;
      for (int i = 1; i < NS; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // overlap and contact decision
  assign sb_last = sb_q[NS-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ct_magx_q       <= sb_last.magx;
      ct_magy_q       <= sb_last.magy;
      ct_rr_q         <= rr[PW-1:0];
      ct_sb_q.negx    <= sb_last.negx;
      ct_sb_q.negy    <= sb_last.negy;
      ct_sb_q.rr0     <= (rr == '0);
      ct_sb_q.contact <= sb_last.pass && (rr < {1'b0, sb_last.a.rs});
      ct_sb_q.xi      <= sb_last.a.rs - rr[PW-1:0];
      ct_sb_q.dvx     <= sb_last.a.dvx;
      ct_sb_q.dvy     <= sb_last.a.dvy;
      ct_sb_q.stiff   <= sb_last.a.stiff;
      ct_sb_q.damp    <= sb_last.a.damp;
      ct_sb_q.flags   <= sb_last.a.flags;
    end
  end

  cfp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ct_magx_q),
    .den_i (ct_rr_q),
    .q_o   (div_x)
  );

  cfp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ct_magy_q),
    .den_i (ct_rr_q),
    .q_o   (div_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_q[0] <= ct_sb_q;
      for (int i = 1; i < ND; i++) begin
        sc_q[i] <= sc_q[i-1];
      end
    end
  end

  // coincident centres give a zero normal
  assign sc_last = sc_q[ND-1];

  always_comb begin
    fin.qx            = sc_last.rr0 ? '0 : div_x;
    fin.qy            = sc_last.rr0 ? '0 : div_y;
    fin.neg_x         = sc_last.negx;
    fin.neg_y         = sc_last.negy;
    fin.dvx           = sc_last.dvx;
    fin.dvy           = sc_last.dvy;
    fin.xi            = sc_last.xi;
    fin.stiffness_sum = sc_last.stiff;
    fin.damping_sum   = sc_last.damp;
    fin.free_flags    = sc_last.flags;
    fin.in_contact    = sc_last.contact;
  end

  cfp_force u_force (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (fin),
    .out_o (fout)
  );

  assign force_o.valid = valid_q[NP-1];
  assign force_o.data  = fout;

  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && !force_o.ready |-> !pair_i.ready)
    else $error("input taken while output stalled");

  a_no_contact_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && !force_o.data.in_contact |->
      force_o.data.a_force_x == '0 && force_o.data.a_force_y == '0 &&
      force_o.data.b_force_x == '0 && force_o.data.b_force_y == '0)
    else $error("force without contact");

  a_opposite_forces : assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && force_o.data.a_force_x != '0 && force_o.data.b_force_x != '0 &&
      force_o.data.a_force_x != 32'sh80000000 &&
      force_o.data.b_force_x != 32'sh80000000 |->
      force_o.data.a_force_x == -force_o.data.b_force_x)
    else $error("pair forces not opposite");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the pair contact force pipeline
`default_nettype none

module tb_top;

  localparam int unsigned SETTLE      = cfp_pkg::PIPE_LAT + 20;
  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  cfp_cfg_if   cfg();
  cfp_pair_if  pair();
  cfp_force_if frc();

  contact_force_pair uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg),
    .pair_i  (pair),
    .force_o (frc)
  );

  longint unsigned          box_w;
  longint unsigned          box_h;
  cfp_pkg::force_t          pending_forces[$];
  int unsigned              mismatches;
  int unsigned              cycles;
  bit                       idle_on;
  int unsigned              hold_req;
  int unsigned              hold_ack;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint fold_axis(longint d, longint unsigned len);
    longint l;
    longint m;
    if (len == 0) return d;
    l = longint'(len);
    m = d % l;
    if (m < 0) m += l;
    if (2 * m > l) m -= l;
    return m;
  endfunction

  function automatic longint unsigned mul_floor(longint unsigned a, longint unsigned b,
                                                int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[63:0] >> s | p[127:64] << (64 - s);
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint mul_trunc(longint a, longint b, int unsigned s);
    longint m;
    m = longint'(mul_floor(magn(a), magn(b), s));
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [cfp_pkg::FIX_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic cfp_pkg::force_t predict_force(cfp_pkg::pair_t p);
    cfp_pkg::force_t f;
    longint          dx, dy, rs, xi, ex, ey, dvx, dvy, xidot, fn, fx, fy;
    longint unsigned rr;
    f = '0;
    ex = 0;
    ey = 0;
    dx = fold_axis(longint'($signed(p.a_pos_x)) - longint'($signed(p.b_pos_x)), box_w);
    dy = fold_axis(longint'($signed(p.a_pos_y)) - longint'($signed(p.b_pos_y)), box_h);
    rs = longint'(p.radius_sum);
    if (!(longint'(magn(dx)) < rs && longint'(magn(dy)) < rs)) return f;
    rr = int_sqrt(magn(dx) * magn(dx) + magn(dy) * magn(dy));
    xi = rs - longint'(rr);
    if (xi <= 0) return f;
    f.in_contact = 1'b1;
    if (rr != 0) begin
      ex = longint'((magn(dx) << 30) / rr);
      ey = longint'((magn(dy) << 30) / rr);
      if (dx < 0) ex = -ex;
      if (dy < 0) ey = -ey;
    end
    dvx = longint'($signed(p.a_vel_x)) - longint'($signed(p.b_vel_x));
    dvy = longint'($signed(p.a_vel_y)) - longint'($signed(p.b_vel_y));
    xidot = -(mul_trunc(ex, dvx, 30) + mul_trunc(ey, dvy, 30));
    fn = longint'(mul_floor(longint'(p.stiffness_sum), xi, 17))
       + mul_trunc(longint'(p.damping_sum), xidot, 17);
    if (fn < 0) fn = 0;
    fx = mul_trunc(fn, ex, 30);
    fy = mul_trunc(fn, ey, 30);
    if (p.free_flags[0]) begin
      f.a_force_x = clamp32(fx);
      f.a_force_y = clamp32(fy);
    end
    if (p.free_flags[1]) begin
      f.b_force_x = clamp32(-fx);
      f.b_force_y = clamp32(-fy);
    end
    return f;
  endfunction

  task automatic send_pair(cfp_pkg::pair_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pair.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    pair.valid <= 1'b1;
    pair.data  <= p;
    do @(posedge clk); while (!pair.ready);
    pending_forces.push_back(predict_force(p));
  endtask

  task automatic stop_sending();
    pair.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_box(cfp_pkg::cfg_reg_e idx, longint unsigned value);
    cfg.valid <= 1'b1;
    cfg.data  <= '{index: idx, value: value[cfp_pkg::POS_W-1:0]};
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == cfp_pkg::CFG_BOX_WIDTH) box_w = value & 64'h7fffffff;
    else box_h = value & 64'h7fffffff;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // pair with a short separation so that contact is likely, possibly across the box edge
  function automatic cfp_pkg::pair_t near_pair();
    cfp_pkg::pair_t p;
    longint         r, dx, dy;
    r  = $urandom_range(1, 1 << 22);
    dx = longint'($urandom_range(0, 2 * r)) - r;
    dy = longint'($urandom_range(0, 2 * r)) - r;
    p.a_pos_x = rnd32();
    p.a_pos_y = rnd32();
    p.b_pos_x = 32'(longint'($signed(p.a_pos_x)) - dx
              + longint'($urandom_range(0, 2)) * longint'(box_w) - longint'(box_w));
    p.b_pos_y = 32'(longint'($signed(p.a_pos_y)) - dy
              + longint'($urandom_range(0, 2)) * longint'(box_h) - longint'(box_h));
    if ($urandom_range(0, 1)) begin
      p.a_vel_x = rnd32();
      p.a_vel_y = rnd32();
      p.b_vel_x = rnd32();
      p.b_vel_y = rnd32();
    end else begin
      p.a_vel_x = $signed(rnd32()) >>> 12;
      p.a_vel_y = $signed(rnd32()) >>> 12;
      p.b_vel_x = $signed(rnd32()) >>> 12;
      p.b_vel_y = $signed(rnd32()) >>> 12;
    end
    p.radius_sum    = 31'(r);
    p.stiffness_sum = 31'($urandom_range(0, 1) ? rnd32() : rnd32() >> 12);
    p.damping_sum   = 31'($urandom_range(0, 1) ? rnd32() : rnd32() >> 12);
    p.free_flags    = 2'($urandom_range(0, 3));
    return p;
  endfunction

  function automatic cfp_pkg::pair_t noise_pair();
    cfp_pkg::pair_t p;
    p.a_pos_x = rnd32();
    p.a_pos_y = rnd32();
    p.b_pos_x = rnd32();
    p.b_pos_y = rnd32();
    p.a_vel_x = rnd32();
    p.a_vel_y = rnd32();
    p.b_vel_x = rnd32();
    p.b_vel_y = rnd32();
    p.radius_sum    = 31'(rnd32());
    p.stiffness_sum = 31'(rnd32());
    p.damping_sum   = 31'(rnd32());
    p.free_flags    = 2'($urandom_range(0, 3));
    return p;
  endfunction

  function automatic cfp_pkg::pair_t make_pair(logic signed [31:0] ax, logic signed [31:0] ay,
                                      logic signed [31:0] bx, logic signed [31:0] by,
                                      logic signed [31:0] vax, logic signed [31:0] vbx,
                                      logic [30:0] r, logic [30:0] k, logic [30:0] c,
                                      logic [1:0] fl);
    cfp_pkg::pair_t p;
    p = '{a_pos_x: ax, a_pos_y: ay, b_pos_x: bx, b_pos_y: by,
          a_vel_x: vax, a_vel_y: -vax, b_vel_x: vbx, b_vel_y: -vbx,
          radius_sum: r, stiffness_sum: k, damping_sum: c, free_flags: fl};
    return p;
  endfunction

  task automatic test_directed();
    idle_on = 1'b0;
    // coincident centres
    send_pair(make_pair(32'sd100, 32'sd100, 32'sd100, 32'sd100, 32'sd65536, 0,
                        31'd65536, 31'd65536, 31'd65536, 2'b11));
    // clear separation, no contact
    send_pair(make_pair(0, 0, 32'sd30000, 32'sd30000, 0, 0, 31'd32768, 31'd65536, 0, 2'b11));
    // inside box prefilter but outside the circle
    send_pair(make_pair(0, 0, 32'sd30000, 32'sd30000, 0, 0, 31'd40000, 31'd65536, 0, 2'b11));
    // plain overlaps with every flag combination
    for (int fl = 0; fl < 4; fl++)
      send_pair(make_pair(0, 0, 32'sd10000, -32'sd5000, 32'sd65536, -32'sd65536,
                          31'd20000, 31'd655360, 31'd65536, fl[1:0]));
    // separating fast: damping drives the force below zero
    send_pair(make_pair(0, 0, 32'sd10000, 0, -32'sd6553600, 32'sd6553600,
                        31'd20000, 31'd65536, 31'h7fffffff, 2'b11));
    // field extremes, saturation of the force
    send_pair(make_pair(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
                        31'h7fffffff, 2'b11));
    send_pair(make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000001,
                        32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
                        31'h7fffffff, 2'b11));
    send_pair(make_pair(0, 0, 32'sd1, 0, 0, 0, 31'd0, 31'd0, 31'd0, 2'b11));
    send_pair(make_pair(0, 0, 32'sd1, 0, 0, 0, 31'd2, 31'd0, 31'd0, 2'b11));
    // fold across the unit box edge and at exactly half a box
    send_pair(make_pair(32'sd1000, 0, 32'sd64536, 0, 0, 0, 31'd5000, 31'd65536,
                        31'd100, 2'b11));
    send_pair(make_pair(32'sd32768, 32'sd32768, 0, 0, 0, 0, 31'd65536, 31'd65536,
                        31'd100, 2'b11));
    send_pair(make_pair(0, 0, 32'sd32768, 32'sd32768, 0, 0, 31'd65536, 31'd65536,
                        31'd100, 2'b11));
    drain();
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_pair($urandom_range(0, 4) == 0 ? noise_pair() : near_pair());
  endtask

  task automatic test_box_settings();
    longint unsigned sizes[6];
    sizes = '{64'd0, 64'd1, 64'h7fffffff, 64'd65536, 64'd1 << 22, 64'd1 << 24};
    idle_on = 1'b1;
    foreach (sizes[i]) begin
      write_box(cfp_pkg::CFG_BOX_WIDTH, sizes[i]);
      write_box(cfp_pkg::CFG_BOX_HEIGHT, sizes[(i + 3) % 6]);
      run_random(70);
      send_pair(make_pair(32'sd100, 0, 32'sh7fffff00, 0, 0, 0, 31'd400, 31'd65536, 0, 2'b11));
      drain();
    end
  endtask

  task automatic test_back_pressure();
    idle_on = 1'b0;
    write_box(cfp_pkg::CFG_BOX_WIDTH, 64'd1 << 23);
    write_box(cfp_pkg::CFG_BOX_HEIGHT, 64'd1 << 23);
    hold_req = hold_req + 1;
    run_random(200);
    drain();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    write_box(cfp_pkg::CFG_BOX_WIDTH, $urandom_range(1 << 20, 1 << 25));
    write_box(cfp_pkg::CFG_BOX_HEIGHT, $urandom_range(1 << 20, 1 << 25));
    run_random(60);
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver ready: long hold when requested, random stall bursts when idle_on is set
  initial begin
    frc.ready <= 1'b1;
    forever begin
      if (hold_req != hold_ack) begin
        frc.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ack = hold_req;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        frc.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        frc.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cfp_pkg::force_t exp_f;
    cfp_pkg::force_t got;
    if (rst_n && frc.valid && frc.ready) begin
      got = frc.data;
      if (pending_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", got);
      end else begin
        exp_f = pending_forces.pop_front();
        if (got.in_contact !== exp_f.in_contact || got.a_force_x !== exp_f.a_force_x ||
            got.a_force_y !== exp_f.a_force_y || got.b_force_x !== exp_f.b_force_x ||
            got.b_force_y !== exp_f.b_force_y) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p got %p", exp_f, got);
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg.valid   <= 1'b0;
    cfg.data    <= '0;
    pair.valid  <= 1'b0;
    pair.data   <= '0;
    box_w       = 65536;
    box_h       = 65536;
    idle_on     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_box_settings();
    test_back_pressure();
    test_streaming();
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
